@@ hdl/osmc_pkg.sv @@
// Shared types and constants for the offset symbol modular exponentiation cipher.
package osmc_pkg;

  localparam int SYM_BITS       = 33;
  localparam int CFG_BITS       = 32;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [SYM_BITS-1:0] SYM_OFFSET = 33'd96;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS  = 1'b1;

  localparam logic [CFG_BITS-1:0] EXPONENT_RESET = 32'd17;
  localparam logic [CFG_BITS-1:0] MODULUS_RESET  = 32'd3233;

  typedef struct packed {
    logic [SYM_BITS-1:0] symbol;
    logic                last_symbol;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_BITS-1:0] coded_symbol;
    logic                last_symbol_out;
  } out_beat_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic red_step;
    logic mul_init;
    logic mul_sel_sq;
    logic mul_step;
    logic store_res;
    logic store_sq;
    logic exp_shift;
    logic out_load;
  } osmc_cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic exp_bit;
    logic out_free;
  } osmc_status_t;

endpackage

@@ hdl/osmc_datapath.sv @@
// Datapath: key registers, base reduction, bit-serial modular multiplier and result register.
module osmc_datapath import osmc_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  in_beat_t                  in_data,
  input  osmc_cmd_t                 cmd,
  output osmc_status_t              status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_beat_t                 out_data
);

  localparam int CW       = (WORD_BITS < CFG_BITS) ? WORD_BITS : CFG_BITS;
  localparam int SUM_BITS = ((WORD_BITS > SYM_BITS) ? WORD_BITS : SYM_BITS) + 1;

  logic [CFG_BITS-1:0]  exponent;
  logic [CFG_BITS-1:0]  modulus;
  logic [WORD_BITS-1:0] m_w;
  logic [WORD_BITS-1:0] e_w;
  logic                 small_mod;

  logic [SYM_BITS-1:0]  base;
  logic                 last;
  logic [WORD_BITS-1:0] exp_sr;
  logic [WORD_BITS-1:0] res;
  logic [WORD_BITS-1:0] sq;
  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] y;
  logic [WORD_BITS-1:0] acc;

  logic [WORD_BITS:0]   red_t;
  logic [WORD_BITS:0]   red_r;
  logic [WORD_BITS-1:0] rem_next;
  logic [WORD_BITS:0]   dbl_s;
  logic [WORD_BITS:0]   dbl_r;
  logic [WORD_BITS:0]   add_s;
  logic [WORD_BITS:0]   add_r;
  logic [WORD_BITS-1:0] acc_next;
  logic [SUM_BITS-1:0]  coded_sum;

  assign m_w       = WORD_BITS'(modulus[CW-1:0]);
  assign e_w       = WORD_BITS'(exponent[CW-1:0]);
  assign small_mod = (m_w < WORD_BITS'(2));

  // One restoring step of base mod n: shift in the next base bit, subtract n if it fits.
  assign red_t    = {sq, base[SYM_BITS-1]};
  assign red_r    = (red_t >= {1'b0, m_w}) ? (red_t - {1'b0, m_w}) : red_t;
  assign rem_next = red_r[WORD_BITS-1:0];

  // One multiplier bit: acc = 2*acc mod n, then add x mod n when the multiplier bit is set.
  assign dbl_s    = {acc, 1'b0};
  assign dbl_r    = (dbl_s >= {1'b0, m_w}) ? (dbl_s - {1'b0, m_w}) : dbl_s;
  assign add_s    = {1'b0, dbl_r[WORD_BITS-1:0]} + {1'b0, x};
  assign add_r    = (add_s >= {1'b0, m_w}) ? (add_s - {1'b0, m_w}) : add_s;
  assign acc_next = y[WORD_BITS-1] ? add_r[WORD_BITS-1:0] : dbl_r[WORD_BITS-1:0];

  assign coded_sum = SUM_BITS'(res) + SUM_BITS'(SYM_OFFSET);

  assign status.exp_bit  = exp_sr[0];
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXPONENT_RESET;
      modulus  <= MODULUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPONENT: exponent <= cfg_data;
        CFG_MODULUS:  modulus  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base   <= in_data.symbol - SYM_OFFSET;
      last   <= in_data.last_symbol;
      exp_sr <= e_w;
    end else begin
      if (cmd.red_step) begin
        base <= {base[SYM_BITS-2:0], 1'b0};
      end
      if (cmd.exp_shift) begin
        exp_sr <= exp_sr >> 1;
      end
    end

    if (cmd.load) begin
      res <= WORD_BITS'(1);
    end else if (cmd.store_res) begin
      res <= acc_next;
    end

    if (cmd.load) begin
      sq <= '0;
    end else if (cmd.red_step) begin
      sq <= rem_next;
    end else if (cmd.store_sq) begin
      sq <= acc_next;
    end

    if (cmd.mul_init) begin
      x   <= cmd.mul_sel_sq ? sq : res;
      y   <= sq;
      acc <= '0;
    end else if (cmd.mul_step) begin
      y   <= {y[WORD_BITS-2:0], 1'b0};
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.coded_symbol    <= small_mod ? SYM_OFFSET : coded_sum[SYM_BITS-1:0];
      out_data.last_symbol_out <= last;
    end
  end

endmodule

@@ hdl/osmc_controller.sv @@
// Sequencer: steps the base reduction, the exponent scan and each bit-serial multiply.
module osmc_controller import osmc_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  osmc_status_t status,
  output osmc_cmd_t    cmd
);

  localparam int CNT_BITS = $clog2((WORD_BITS > SYM_BITS) ? WORD_BITS : SYM_BITS);
  localparam int EXP_BITS = $clog2(WORD_BITS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_DECIDE = 6'b000100,
    S_MUL    = 6'b001000,
    S_SQR    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CNT_BITS-1:0] mcnt;
  logic [CNT_BITS-1:0] mcnt_next;
  logic [EXP_BITS-1:0] ecnt;
  logic [EXP_BITS-1:0] ecnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mcnt  <= '0;
      ecnt  <= '0;
    end else begin
      state <= state_next;
      mcnt  <= mcnt_next;
      ecnt  <= ecnt_next;
    end
  end

  always_comb begin
    state_next = state;
    mcnt_next  = mcnt;
    ecnt_next  = ecnt;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          mcnt_next  = CNT_BITS'(SYM_BITS - 1);
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.red_step = 1'b1;
        if (mcnt == '0) begin
          ecnt_next  = EXP_BITS'(WORD_BITS - 1);
          state_next = S_DECIDE;
        end else begin
          mcnt_next = mcnt - 1'b1;
        end
      end
      S_DECIDE: begin
        // A set exponent bit multiplies the result by the current square first.
        cmd.mul_init   = 1'b1;
        cmd.mul_sel_sq = !status.exp_bit;
        mcnt_next      = CNT_BITS'(WORD_BITS - 1);
        state_next     = status.exp_bit ? S_MUL : S_SQR;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (mcnt == '0) begin
          cmd.store_res  = 1'b1;
          cmd.mul_init   = 1'b1;
          cmd.mul_sel_sq = 1'b1;
          mcnt_next      = CNT_BITS'(WORD_BITS - 1);
          state_next     = S_SQR;
        end else begin
          mcnt_next = mcnt - 1'b1;
        end
      end
      S_SQR: begin
        cmd.mul_step = 1'b1;
        if (mcnt == '0) begin
          cmd.store_sq  = 1'b1;
          cmd.exp_shift = 1'b1;
          if (ecnt == '0) begin
            state_next = S_FINISH;
          end else begin
            ecnt_next  = ecnt - 1'b1;
            state_next = S_DECIDE;
          end
        end else begin
          mcnt_next = mcnt - 1'b1;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/offset_symbol_modexp_cipher.sv @@
// Top level: modular exponentiation of offset symbols, one symbol at a time.
//
//   Channel  Direction  Handshake            Beat
//   in       input      in_valid / in_stall  in_beat_t (symbol, last_symbol)
//   out      output     out_valid / out_stall out_beat_t (coded_symbol, last_symbol_out)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// A symbol is loaded, its base reduced mod n bit by bit, then each of the W = WORD_BITS
// exponent bits brings a multiply into the result when set and a squaring, before the
// result is loaded out; a single shared multiplier retires one multiplier bit per cycle.
// Reset is synchronous and active high; it restores the exponent to 17 and the modulus
// to 3233 and empties the result register. A stalled result stays in its register while
// the next symbol is taken; that symbol then waits at the end until the register frees.
module offset_symbol_modexp_cipher import osmc_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_beat_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_beat_t                 out_data
);

  osmc_cmd_t    cmd;
  osmc_status_t status;

  osmc_controller #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  osmc_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/osmc_checker.sv @@
// Port-level checks on the cipher top level, attached by bind.
module osmc_checker import osmc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // The result register empties on reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result still valid after reset");

  // One symbol at a time: taking a beat makes the input side busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a beat was taken");

  // A new result only appears while a symbol was being worked on.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no symbol in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind offset_symbol_modexp_cipher osmc_checker u_osmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/offset_symbol_modexp_cipher_tb.sv @@
// Self-checking testbench for the offset symbol modular exponentiation cipher.
`timescale 1ns / 100ps

module offset_symbol_modexp_cipher_tb import osmc_pkg::*;;

  localparam int WORD_BITS  = 32;
  localparam int LONG_HOLD  = 9000;
  localparam int DRAIN      = 2200;
  localparam int CYCLE_CAP  = 3000000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 33;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_EXPONENT;
  logic [CFG_BITS-1:0]       cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  in_beat_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_beat_t                 out_data;

  // Copy of the key registers as the block should hold them.
  logic [CFG_BITS-1:0] key_exponent = EXPONENT_RESET;
  logic [CFG_BITS-1:0] key_modulus  = MODULUS_RESET;

  in_beat_t  pending_beats[$];
  out_beat_t coded_q[$];

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic idle_on   = 1'b1;
  logic hold_req  = 1'b0;
  int   send_gap  = 0;
  int   recv_gap  = 0;
  int   long_hold = 0;
  int   next_wait = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  offset_symbol_modexp_cipher #(.WORD_BITS(WORD_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Square-and-multiply over the low WORD_BITS exponent bits, every product reduced mod n.
  function automatic out_beat_t encode_symbol(in_beat_t beat);
    logic [SYM_BITS-1:0] base;
    logic [63:0]         n;
    logic [63:0]         power;
    logic [63:0]         square;
    out_beat_t           coded;
    base = beat.symbol - SYM_OFFSET;
    n = {32'd0, key_modulus};
    power = 64'd0;
    if (n >= 64'd2) begin
      power = 64'd1;
      square = {31'd0, base} % n;
      for (int i = 0; i < WORD_BITS; i++) begin
        if (key_exponent[i]) power = (power * square) % n;
        square = (square * square) % n;
      end
    end
    coded.coded_symbol = power[SYM_BITS-1:0] + SYM_OFFSET;
    coded.last_symbol_out = beat.last_symbol;
    return coded;
  endfunction

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, 10) : 0;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t            beat;
    logic                top;
    logic [SYM_BITS-1:0] sym;
    top = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: sym = SYM_BITS'($urandom_range(0, 95));
      1: sym = {1'b0, key_modulus} + SYM_OFFSET - SYM_BITS'($urandom_range(0, 2));
      2: sym = {top, $urandom};
      3: sym = SYM_OFFSET + SYM_BITS'($urandom_range(0, 255));
      default: sym = SYM_OFFSET + {1'b0, $urandom};
    endcase
    beat.symbol = sym;
    beat.last_symbol = 1'($urandom_range(0, 1));
    return beat;
  endfunction

  task automatic queue_symbol(logic [SYM_BITS-1:0] sym, logic last);
    in_beat_t beat;
    beat.symbol = sym;
    beat.last_symbol = last;
    pending_beats.push_back(beat);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_EXPONENT) key_exponent = value;
    else key_modulus = value;
  endtask

  task automatic set_key(logic [CFG_BITS-1:0] e, logic [CFG_BITS-1:0] n);
    write_reg(CFG_EXPONENT, e);
    write_reg(CFG_MODULUS, n);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || coded_q.size() != 0);
  endtask

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Sender: a beat stays up until taken, then the drawn gap runs before the next one.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_beats.size() != 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        send_gap <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) coded_q.push_back(encode_symbol(in_data));
  end

  // Receiver: the drawn stall is counted only while a result is on offer.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
      long_hold <= 0;
    end else if (hold_req && long_hold == 0) begin
      long_hold <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (long_hold != 0) begin
      long_hold <= long_hold - 1;
      out_stall <= (long_hold != 1);
    end else if (out_taken) begin
      next_wait = draw_gap();
      recv_gap <= next_wait;
      out_stall <= (next_wait != 0);
    end else if (out_valid && recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= (recv_gap != 1);
    end else begin
      out_stall <= (recv_gap != 0);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    out_taken <= !rst && out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      if (coded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat coded=%0d last=%0b",
                                  out_data.coded_symbol, out_data.last_symbol_out));
      end else begin
        want = coded_q.pop_front();
        if (want.coded_symbol !== out_data.coded_symbol ||
            want.last_symbol_out !== out_data.last_symbol_out) begin
          report_mismatch($sformatf("coded exp=%0d act=%0d, last exp=%0b act=%0b",
                                    want.coded_symbol, out_data.coded_symbol,
                                    want.last_symbol_out, out_data.last_symbol_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [CFG_BITS-1:0] e_pick;
    logic [CFG_BITS-1:0] n_pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset key: zero base, base equal to n and above, wrap below the offset, top values.
    queue_symbol(33'd96, 1'b0);
    queue_symbol(33'd97, 1'b0);
    queue_symbol(33'd96 + 33'd3232, 1'b0);
    queue_symbol(33'd96 + 33'd3233, 1'b1);
    queue_symbol(33'd96 + 33'd5000, 1'b0);
    queue_symbol(33'd0, 1'b0);
    queue_symbol(33'd95, 1'b1);
    queue_symbol(33'h1_FFFF_FFFF, 1'b1);
    queue_symbol(33'h1_0000_005F, 1'b0);
    queue_symbol(33'd162, 1'b1);
    wait_idle();

    // Exponent zero gives one for every base.
    set_key(32'd0, 32'hFFFF_FFFF);
    queue_symbol(33'd96, 1'b0);
    queue_symbol(33'h1_FFFF_FFFF, 1'b1);
    queue_symbol(33'd1000, 1'b0);
    wait_idle();

    set_key(32'hFFFF_FFFF, 32'd2);
    queue_symbol(33'd96, 1'b0);
    queue_symbol(33'd97, 1'b1);
    queue_symbol(33'd98, 1'b0);
    queue_symbol(33'h1_FFFF_FFFF, 1'b1);
    wait_idle();

    // Degenerate moduli give a zero power.
    set_key(32'd5, 32'd1);
    queue_symbol(33'd100, 1'b1);
    wait_idle();
    write_reg(CFG_MODULUS, 32'd0);
    queue_symbol(33'd100, 1'b0);
    queue_symbol(33'h1_FFFF_FFFF, 1'b1);
    wait_idle();

    set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_symbol(33'h1_FFFF_FFFF, 1'b0);
    queue_symbol(33'h1_0000_005E, 1'b0);
    queue_symbol(33'h1_0000_005F, 1'b1);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: e_pick = $urandom;
        1: e_pick = $urandom_range(0, 15);
        2: e_pick = 32'd65537;
        default: e_pick = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 3))
        0: n_pick = $urandom_range(2, 4000);
        1: n_pick = $urandom | 32'h8000_0000;
        2: n_pick = $urandom_range(32'hFFFF_FFFF, 2);
        default: n_pick = 32'hFFFF_FFFF;
      endcase
      set_key(e_pick, n_pick);
      idle_on = (ph % 3 != 2);
      if (ph == 1) begin
        // Hold results off long enough that the block fills and stalls its input.
        @(posedge clk);
        hold_req = 1'b1;
        @(posedge clk);
        hold_req = 1'b0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) pending_beats.push_back(random_beat());
      wait_idle();
    end

    repeat (DRAIN) @(posedge clk);
    if (coded_q.size() != 0) report_mismatch("results still outstanding at the end");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
